### rtl/core/tafir_pkg.sv
// Package for the three-axis low-pass FIR: sizes, the coefficient table and
// the coefficient lookup used by the tap cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tafir_pkg;

	localparam int TAP_COUNT = 29;
	localparam int COEF_BITS = 16;
	localparam int TABLE_LEN = 29;
	localparam int AXES      = 3;
	localparam int SAMPLE_W  = 16;

	// Product of one sample and one coefficient, and the partial-sum width
	// with growth room for every tap.
	localparam int PROD_W = SAMPLE_W + COEF_BITS;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
	localparam int SHIFT  = COEF_BITS - 1;
	localparam int QUOT_W = ACC_W - SHIFT;

	// Published coefficient set rounded to Q1.15.
	localparam int LP_Q15 [TABLE_LEN] = '{
		-59, -62, -66, -55, 0, 126, 348, 675, 1101, 1599, 2125, 2622, 3032, 3301,
		3396,
		3301, 3032, 2622, 2125, 1599, 1101, 675, 348, 126, 0, -55, -66, -62, -59
	};

	// Coefficient of tap k in Q1.(COEF_BITS-1). Finer formats scale exactly,
	// coarser ones round half up; taps past the table are zero.
	function automatic logic signed [COEF_BITS-1:0] coef_at(input int k);
		int c;
		int s;
		int r;
		c = 0;
		if (k >= 0 && k < TABLE_LEN) begin
			c = LP_Q15[k];
			if (COEF_BITS >= 16) begin
				s = COEF_BITS - 16;
				c = c * (1 << s);
			end else begin
				s = 16 - COEF_BITS;
				r = ((c + 32768) + (1 << (s - 1))) >> s;
				c = r - (32768 >> s);
			end
		end
		return COEF_BITS'(c);
	endfunction

endpackage
`default_nettype wire

### rtl/core/tafir_ifs.sv
// Valid/ready channel interfaces for the three-axis FIR: one for sample
// items in, one for filtered items out. Depends on tafir_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tafir_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tafir_pkg::SAMPLE_W-1:0] sample_x;
	logic signed [tafir_pkg::SAMPLE_W-1:0] sample_y;
	logic signed [tafir_pkg::SAMPLE_W-1:0] sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface tafir_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tafir_pkg::SAMPLE_W-1:0] filtered_x;
	logic signed [tafir_pkg::SAMPLE_W-1:0] filtered_y;
	logic signed [tafir_pkg::SAMPLE_W-1:0] filtered_z;

	modport source (output valid, output filtered_x, output filtered_y,
		output filtered_z, input ready);
	modport sink (input valid, input filtered_x, input filtered_y, input filtered_z,
		output ready);
endinterface
`default_nettype wire

### rtl/core/tafir_cell.sv
// One tap of a transposed FIR chain: multiplies the sample by its coefficient
// and adds the partial sum handed over by its neighbor. Depends on tafir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tafir_cell (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic signed [tafir_pkg::SAMPLE_W-1:0] sample,
	input  wire logic signed [tafir_pkg::COEF_BITS-1:0] coef,
	input  wire logic signed [tafir_pkg::ACC_W-1:0]    sum_in,
	output logic signed [tafir_pkg::ACC_W-1:0]         sum_q
);

	logic signed [tafir_pkg::PROD_W-1:0] prod;

	assign prod = coef * sample;

	// The partial sums are the filter state, so reset clears them to match
	// an all-zero sample history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= tafir_pkg::ACC_W'(prod) + sum_in;
		end
	end

endmodule
`default_nettype wire

### rtl/core/tafir_quant.sv
// Output register for the three axes: divides each full sum by the
// coefficient scale, truncating toward zero, and saturates to 16 bits.
// Depends on tafir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tafir_quant (
	input  wire logic                                  clk,
	input  wire logic                                  load,
	input  wire logic signed [tafir_pkg::ACC_W-1:0]    acc [tafir_pkg::AXES],
	output logic signed [tafir_pkg::SAMPLE_W-1:0]      res_q [tafir_pkg::AXES]
);

	localparam int QW = tafir_pkg::QUOT_W;

	logic signed [QW-1:0]                       quot [tafir_pkg::AXES];
	logic signed [tafir_pkg::SAMPLE_W-1:0]      sat  [tafir_pkg::AXES];

	always_comb begin
		for (int a = 0; a < tafir_pkg::AXES; a++) begin
			quot[a] = QW'(acc[a] >>> tafir_pkg::SHIFT);
			// A negative sum with a nonzero fraction rounds up toward zero.
			if (acc[a][tafir_pkg::ACC_W-1] && (|acc[a][tafir_pkg::SHIFT-1:0])) begin
				quot[a] = quot[a] + QW'(1);
			end
			if (quot[a] > $signed(QW'(32767))) begin
				sat[a] = 16'sh7FFF;
			end else if (quot[a] < -$signed(QW'(32768))) begin
				sat[a] = 16'sh8000;
			end else begin
				sat[a] = tafir_pkg::SAMPLE_W'(quot[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= sat;
		end
	end

endmodule
`default_nettype wire

### rtl/core/three_axis_fir_lowpass.sv
// Three-axis 29-tap low-pass FIR, one transposed chain of tap cells per axis.
// A result item is registered in the tap cells and then in the output register
// before it is offered; a result that waits holds the next item in the cells.
// Throughput: one item per cycle unless stalled; a multiply-add per cell per item.
// The output register lets one more item in while a result waits to be taken.
// Reset clears all partial sums (an all-zero history) and both valid flags.
// Depends on tafir_pkg, tafir_ifs, tafir_cell and tafir_quant.
`timescale 1ns / 1ps
`default_nettype none
module three_axis_fir_lowpass (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tafir_in_if.sink     samples,
	tafir_out_if.source  filtered
);

	localparam int T = tafir_pkg::TAP_COUNT;

	logic                                   acc_en;
	logic                                   adv;
	logic                                   v1_q;
	logic                                   v2_q;
	logic signed [tafir_pkg::SAMPLE_W-1:0] smp    [tafir_pkg::AXES];
	logic signed [tafir_pkg::ACC_W-1:0]    sums   [tafir_pkg::AXES][T];
	logic signed [tafir_pkg::ACC_W-1:0]    acc_s1 [tafir_pkg::AXES];
	logic signed [tafir_pkg::SAMPLE_W-1:0] res_s2 [tafir_pkg::AXES];

	assign smp[0] = samples.sample_x;
	assign smp[1] = samples.sample_y;
	assign smp[2] = samples.sample_z;

	// Cell 0 holds the complete sum of the newest item, so its valid flag is
	// the first pipeline stage; the chain moves only when an item is taken.
	assign adv           = v1_q && (!v2_q || filtered.ready);
	assign samples.ready = !v1_q || adv;
	assign acc_en        = samples.valid && samples.ready;

	for (genvar a = 0; a < tafir_pkg::AXES; a++) begin : g_axis
		for (genvar k = 0; k < T; k++) begin : g_tap
			logic signed [tafir_pkg::ACC_W-1:0] nxt;
			if (k == T - 1) begin : g_last
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = sums[a][k+1];
			end
			tafir_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (acc_en),
				.sample (smp[a]),
				.coef   (tafir_pkg::coef_at(k)),
				.sum_in (nxt),
				.sum_q  (sums[a][k])
			);
		end
		assign acc_s1[a] = sums[a][0];
	end

	tafir_quant u_quant (
		.clk   (clk),
		.load  (adv),
		.acc   (acc_s1),
		.res_q (res_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			v1_q <= acc_en || (v1_q && !adv);
			v2_q <= adv || (v2_q && !filtered.ready);
		end
	end

	assign filtered.valid      = v2_q;
	assign filtered.filtered_x = res_s2[0];
	assign filtered.filtered_y = res_s2[1];
	assign filtered.filtered_z = res_s2[2];

endmodule
`default_nettype wire

### tb/axis_filter_checker.sv
// Checker for the three-axis low-pass FIR: keeps its own copy of the delay
// lines, predicts each filtered item and compares it with what the block offers.
// Depends on tafir_pkg and the channel interfaces in tafir_ifs.
`timescale 1ns / 1ps
module axis_filter_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	tafir_in_if       samples,
	tafir_out_if      filtered,
	output int        mismatches,
	output int        outstanding
);
	import tafir_pkg::*;

	localparam int TAPS_PUBLISHED = 29;

	// Low-pass taps in Q1.15, symmetric about the center tap.
	localparam int Q15_TAPS [TAPS_PUBLISHED] = '{
		-59, -62, -66, -55, 0, 126, 348, 675, 1101, 1599, 2125, 2622, 3032, 3301,
		3396,
		3301, 3032, 2622, 2125, 1599, 1101, 675, 348, 126, 0, -55, -66, -62, -59
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] z;
	} triple_t;

	triple_t expected_filtered [$];
	logic signed [SAMPLE_W-1:0] history [AXES][TAP_COUNT-1];

	// Tap weight at the block's coefficient width: exact scaling for wider
	// formats, round half up for narrower ones, zero past the published set.
	function automatic longint tap_weight(input int k);
		longint w;
		int s;
		w = 0;
		if (k < TAPS_PUBLISHED) begin
			w = Q15_TAPS[k];
			if (COEF_BITS >= 16) begin
				w = w * (longint'(1) << (COEF_BITS - 16));
			end else begin
				s = 16 - COEF_BITS;
				w = ((w + 32768 + (longint'(1) << (s - 1))) >>> s) - (32768 >>> s);
			end
		end
		return w;
	endfunction

	// One output sample of one axis; shifts the new sample into that axis' line.
	function automatic logic signed [SAMPLE_W-1:0] filter_axis(input int a,
		input logic signed [SAMPLE_W-1:0] smp);
		longint acc;
		longint q;
		int k;
		acc = tap_weight(0) * longint'(smp);
		for (k = 1; k < TAP_COUNT; k++)
			acc += tap_weight(k) * longint'(history[a][k-1]);
		// Signed division truncates toward zero, as the block must.
		q = acc / (longint'(1) << (COEF_BITS - 1));
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		for (k = TAP_COUNT - 2; k > 0; k--)
			history[a][k] = history[a][k-1];
		history[a][0] = smp;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic compare_field(input string name, input logic signed [SAMPLE_W-1:0] want,
		input logic signed [SAMPLE_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		triple_t want;
		int a;
		int k;
		if (!arst_n) begin
			for (a = 0; a < AXES; a++)
				for (k = 0; k < TAP_COUNT - 1; k++)
					history[a][k] = '0;
			expected_filtered.delete();
			outstanding = 0;
		end else begin
			// Results are checked before new samples are predicted; the block
			// never returns an item in the cycle it takes it.
			if (filtered.valid && filtered.ready) begin
				if (expected_filtered.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item, expected none, actual x=%0d y=%0d z=%0d",
						$time, filtered.filtered_x, filtered.filtered_y, filtered.filtered_z);
				end else begin
					want = expected_filtered.pop_front();
					outstanding--;
					compare_field("filtered_x", want.x, filtered.filtered_x);
					compare_field("filtered_y", want.y, filtered.filtered_y);
					compare_field("filtered_z", want.z, filtered.filtered_z);
				end
			end
			if (samples.valid && samples.ready) begin
				want.x = filter_axis(0, samples.sample_x);
				want.y = filter_axis(1, samples.sample_y);
				want.z = filter_axis(2, samples.sample_z);
				expected_filtered.push_back(want);
				outstanding++;
			end
		end
	end

endmodule

### tb/tb_top.sv
// Top of the three-axis FIR testbench: clock, reset, sample stimulus and the
// result-side stalls; the checker beside the block does all comparing.
// Depends on tafir_pkg, tafir_ifs, three_axis_fir_lowpass and axis_filter_checker.
`timescale 1ns / 1ps
module tb_top;
	import tafir_pkg::*;

	localparam int IDLE_NONE  = 0;
	localparam int IDLE_SOME  = 1;
	localparam int IDLE_HEAVY = 2;

	localparam int MIX_FULL      = 0;
	localparam int MIX_SMALL     = 1;
	localparam int MIX_CORNER    = 2;
	localparam int MIX_NEAR_RAIL = 3;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 190;
	localparam int DIRECTED_ITEMS = 29;

	// Signs of the low-pass taps, oldest to newest; the set is symmetric.
	localparam int TAP_SIGN [DIRECTED_ITEMS] = '{
		-1, -1, -1, -1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
		1, 1, 1, 1, 1, 1, 1, 1, 1, 0, -1, -1, -1, -1
	};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   send_idle;
	int   take_idle;

	tafir_in_if  samples ();
	tafir_out_if filtered ();

	three_axis_fir_lowpass dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.filtered (filtered)
	);

	axis_filter_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.filtered    (filtered),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("[three_axis_fir_lowpass] ERROR");
		$finish;
	end

	function automatic int idle_cycles(input int mode);
		int n;
		n = 0;
		case (mode)
			IDLE_NONE: n = 0;
			IDLE_SOME: n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
			default:   n = $urandom_range(0, 16);
		endcase
		return n;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int mix);
		logic signed [SAMPLE_W-1:0] v;
		case (mix)
			MIX_FULL:  v = SAMPLE_W'($urandom);
			MIX_SMALL: v = SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
			MIX_CORNER: begin
				case ($urandom_range(0, 3))
					0:       v = 16'sh7fff;
					1:       v = 16'sh8000;
					2:       v = 16'sh0000;
					default: v = 16'shffff;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1))
					v = 16'sh7fff - SAMPLE_W'($urandom_range(0, 255));
				else
					v = 16'sh8000 + SAMPLE_W'($urandom_range(0, 255));
			end
		endcase
		return v;
	endfunction

	// Offers one sample item and returns at the edge where it is taken, with
	// valid still high so that back-to-back items need no gap.
	task automatic send_item(input logic signed [SAMPLE_W-1:0] x,
		input logic signed [SAMPLE_W-1:0] y, input logic signed [SAMPLE_W-1:0] z);
		int gap;
		gap = idle_cycles(send_idle);
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid    <= 1'b1;
		samples.sample_x <= x;
		samples.sample_y <= y;
		samples.sample_z <= z;
		do @(posedge clk); while (!samples.ready);
	endtask

	task automatic drain_results();
		samples.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// Result side: a fresh stall for every item, ready held until it is taken.
	initial begin : result_taker
		int stall;
		filtered.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_cycles(take_idle);
			if (stall > 0) begin
				filtered.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			filtered.ready <= 1'b1;
			do @(posedge clk); while (!filtered.valid);
		end
	end

	initial begin : stimulus
		logic signed [SAMPLE_W-1:0] hold_x;
		logic signed [SAMPLE_W-1:0] hold_y;
		logic signed [SAMPLE_W-1:0] hold_z;
		logic signed [SAMPLE_W-1:0] rail;
		int phase;
		int n;
		arst_n           = 1'b0;
		send_idle        = IDLE_NONE;
		take_idle        = IDLE_NONE;
		samples.valid    <= 1'b0;
		samples.sample_x <= '0;
		samples.sample_y <= '0;
		samples.sample_z <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Rails matched to the tap signs drive x into positive and y into
		// negative saturation once the line is full; z = -1 shows truncation
		// toward zero on small negative sums. The first item lands on an
		// all-zero history.
		for (n = 0; n < DIRECTED_ITEMS; n++) begin
			rail = (TAP_SIGN[n] < 0) ? 16'sh8000 : 16'sh7fff;
			send_item(rail, ~rail, 16'shffff);
		end
		drain_results();

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				send_idle = IDLE_NONE;
				take_idle = IDLE_NONE;
			end else begin
				send_idle = $urandom_range(IDLE_NONE, IDLE_HEAVY);
				take_idle = $urandom_range(IDLE_NONE, IDLE_HEAVY);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase % 4 == 3) begin
					// Long runs of values near the rails reach saturation again.
					if (n % 40 == 0) begin
						hold_x = draw_sample($urandom_range(MIX_CORNER, MIX_NEAR_RAIL));
						hold_y = draw_sample($urandom_range(MIX_CORNER, MIX_NEAR_RAIL));
						hold_z = draw_sample($urandom_range(MIX_CORNER, MIX_NEAR_RAIL));
					end
					send_item(hold_x, hold_y, hold_z);
				end else begin
					send_item(draw_sample($urandom_range(MIX_FULL, MIX_NEAR_RAIL)),
						draw_sample($urandom_range(MIX_FULL, MIX_NEAR_RAIL)),
						draw_sample($urandom_range(MIX_FULL, MIX_NEAR_RAIL)));
				end
			end
			if (phase == 4)
				drain_results();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[three_axis_fir_lowpass] OK");
		else
			$display("[three_axis_fir_lowpass] ERROR");
		$finish;
	end

endmodule
